// File: rtl/rse_pkg.sv
// Shared types and constants for the RGB Sobel edge enhancer.
// No dependencies.
package rse_pkg;
    localparam int CFG_W = 12;
    localparam int COORD_W = 11;
    localparam int PIX_W = 8;
    localparam logic [0:0] REG_WIDTH = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    // job handed from front to back: one pixel, classified
    typedef struct packed {
        logic [PIX_W-1:0] c0, c1, c2, c3, c4, c5, c6, c7, c8; // window, row-major
        logic [PIX_W-1:0] gray;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic interior;
        logic border;
    } job_t;
endpackage

// File: rtl/rse_front.sv
// Front end: gray conversion, line stores, window, classification.
// Depends on rse_pkg.
module rse_front #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic cfg_we,
    input  logic [0:0] cfg_idx,
    input  logic cfg_known,
    input  logic [rse_pkg::CFG_W-1:0] cfg_data,
    input  logic s_valid,
    output logic s_ready,
    input  logic [7:0] s_red,
    input  logic [7:0] s_green,
    input  logic [7:0] s_blue,
    output logic job_valid,
    input  logic job_ready,
    output rse_pkg::job_t job
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int CW = (WW > rse_pkg::CFG_W) ? WW : rse_pkg::CFG_W;
    localparam int CH = (HW > rse_pkg::CFG_W) ? HW : rse_pkg::CFG_W;

    logic [rse_pkg::CFG_W-1:0] width_reg, height_reg;
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [WW-1:0] col_reg;
    logic [HW-1:0] row_reg;
    logic [7:0] line1 [MAX_WIDTH];
    logic [7:0] line2 [MAX_WIDTH];
    logic [7:0] win_reg [9];
    logic [9:0] sum3;
    logic [7:0] gray;
    logic [AW-1:0] ci;
    logic take;
    logic busy_reg;
    logic emit;
    logic [7:0] gray_reg, up1_reg, up2_reg;
    logic [AW-1:0] ci_reg;

    // effective sizes: zero reads as one, saturate at maximum
    always_comb begin
        if (width_reg == '0) w_eff = WW'(1);
        else if (CW'(width_reg) > CW'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
        else w_eff = WW'(width_reg);
        if (height_reg == '0) h_eff = HW'(1);
        else if (CH'(height_reg) > CH'(MAX_HEIGHT)) h_eff = HW'(MAX_HEIGHT);
        else h_eff = HW'(height_reg);
    end

    // divide by three via reciprocal: floor(x*683 >> 11) exact for x < 1024
    assign sum3 = 10'(s_red) + 10'(s_green) + 10'(s_blue);
    assign gray = 8'((21'(sum3) * 21'd683) >> 11);
    assign ci = col_reg[AW-1:0];
    // one pixel at a time: accept and read the stores, then write and hand on once the job output is free
    assign s_ready = !busy_reg;
    assign take = s_valid && s_ready;
    assign emit = busy_reg && (!job_valid || job_ready);

    // line stores: registered read on accept, write back when the job leaves
    always_ff @(posedge aclk) begin
        if (take) begin
            up2_reg <= line2[ci];
            up1_reg <= line1[ci];
        end
        if (emit) begin
            line2[ci_reg] <= up1_reg;
            line1[ci_reg] <= gray_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= rse_pkg::CFG_W'(640);
            height_reg <= rse_pkg::CFG_W'(480);
            col_reg <= '0;
            row_reg <= '0;
            job_valid <= 1'b0;
            busy_reg <= 1'b0;
            for (int i = 0; i < 9; i++) win_reg[i] <= '0;
        end else begin
            if (job_valid && job_ready) job_valid <= 1'b0;
            if (cfg_we && cfg_known) begin
                if (cfg_idx == rse_pkg::REG_WIDTH) width_reg <= cfg_data;
                else height_reg <= cfg_data;
                col_reg <= '0;
                row_reg <= '0;
            end else if (take) begin
                busy_reg <= 1'b1;
                gray_reg <= gray;
                ci_reg <= ci;
            end else if (emit) begin
                busy_reg <= 1'b0;
                for (int i = 0; i < 3; i++) begin
                    win_reg[i*3] <= win_reg[i*3+1];
                    win_reg[i*3+1] <= win_reg[i*3+2];
                end
                win_reg[2] <= up2_reg;
                win_reg[5] <= up1_reg;
                win_reg[8] <= gray_reg;
                job_valid <= 1'b1;
                job.c0 <= win_reg[1]; job.c1 <= win_reg[2]; job.c2 <= up2_reg;
                job.c3 <= win_reg[4]; job.c4 <= win_reg[5]; job.c5 <= up1_reg;
                job.c6 <= win_reg[7]; job.c7 <= win_reg[8]; job.c8 <= gray_reg;
                job.gray <= gray_reg;
                job.row <= rse_pkg::COORD_W'(row_reg);
                job.col <= rse_pkg::COORD_W'(col_reg);
                job.interior <= (row_reg >= HW'(2)) && (col_reg >= WW'(2))
                    && (row_reg < h_eff) && (col_reg < w_eff);
                job.border <= (row_reg == '0) || (col_reg == '0)
                    || ((HW+1)'(row_reg) + 1'b1 >= (HW+1)'(h_eff))
                    || ((WW+1)'(col_reg) + 1'b1 >= (WW+1)'(w_eff));
                if ((WW+1)'(col_reg) + 1'b1 >= (WW+1)'(w_eff)) begin
                    col_reg <= '0;
                    if ((HW+1)'(row_reg) + 1'b1 >= (HW+1)'(h_eff)) row_reg <= '0;
                    else row_reg <= row_reg + 1'b1;
                end else begin
                    col_reg <= col_reg + 1'b1;
                end
            end
        end
    end
endmodule

// File: rtl/rse_fifo.sv
// Short queue of classified jobs between front and back.
// Depends on rse_pkg.
module rse_fifo (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  rse_pkg::job_t in_job,
    output logic out_valid,
    input  logic out_ready,
    output rse_pkg::job_t out_job
);
    rse_pkg::job_t mem [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic wr, rd;

    assign in_ready = cnt_reg != 3'd4;
    assign out_valid = cnt_reg != 3'd0;
    assign out_job = mem[rp_reg];
    assign wr = in_valid && in_ready;
    assign rd = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (wr) mem[wp_reg] <= in_job;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= wp_reg + 1'b1;
            if (rd) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + 3'(wr) - 3'(rd);
        end
    end
endmodule

// File: rtl/rse_back.sv
// Back end: Sobel gradient, bitwise square root, enhancement, result emission.
// Depends on rse_pkg.
module rse_back (
    input  logic aclk,
    input  logic aresetn,
    input  logic job_valid,
    output logic job_ready,
    input  rse_pkg::job_t job,
    output logic m_valid,
    input  logic m_ready,
    output logic [10:0] m_out_row,
    output logic [10:0] m_out_col,
    output logic [7:0] m_enhanced_pixel,
    output logic m_last_of_step
);
    typedef enum logic [1:0] {S_IDLE, S_ROOT, S_OUT1, S_OUT2} state_t;
    state_t state_reg;
    logic [20:0] s_reg;
    logic [7:0] r_reg;
    logic [3:0] bit_reg;
    rse_pkg::job_t j_reg;
    logic signed [11:0] sx, sy;
    logic [7:0] t;
    logic [8:0] enh;
    logic out_free;

    // gradients from the incoming job
    always_comb begin
        sx = 12'(job.c2) + 12'(job.c8) + (12'(job.c5) << 1)
           - 12'(job.c0) - 12'(job.c6) - (12'(job.c3) << 1);
        sy = 12'(job.c6) + 12'(job.c8) + (12'(job.c7) << 1)
           - 12'(job.c0) - 12'(job.c2) - (12'(job.c1) << 1);
    end

    assign t = r_reg | (8'd1 << bit_reg[2:0]);
    assign enh = 9'(j_reg.c4) + 9'(r_reg);
    assign out_free = !m_valid || m_ready;
    assign job_ready = state_reg == S_IDLE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            m_valid <= 1'b0;
        end else begin
            if (m_valid && m_ready) m_valid <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (job_valid) begin
                        j_reg <= job;
                        s_reg <= 21'(24'(sx * sx) + 24'(sy * sy));
                        r_reg <= '0;
                        bit_reg <= 4'd7;
                        if (job.interior) state_reg <= S_ROOT;
                        else if (job.border) state_reg <= S_OUT2;
                    end
                end
                // one result bit per cycle, most significant first
                S_ROOT: begin
                    if (21'(16'(t) * 16'(t)) <= s_reg) r_reg <= t;
                    if (bit_reg == 4'd0) state_reg <= S_OUT1;
                    else bit_reg <= bit_reg - 1'b1;
                end
                S_OUT1: begin
                    if (out_free) begin
                        m_valid <= 1'b1;
                        m_out_row <= j_reg.row - 1'b1;
                        m_out_col <= j_reg.col - 1'b1;
                        m_enhanced_pixel <= enh[8] ? 8'hFF : enh[7:0];
                        m_last_of_step <= !j_reg.border;
                        state_reg <= j_reg.border ? S_OUT2 : S_IDLE;
                    end
                end
                S_OUT2: begin
                    if (out_free) begin
                        m_valid <= 1'b1;
                        m_out_row <= j_reg.row;
                        m_out_col <= j_reg.col;
                        m_enhanced_pixel <= j_reg.gray;
                        m_last_of_step <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// File: rtl/rgb_sobel_edge_enhance.sv
// Top level of the RGB Sobel edge enhancer.
// Depends on rse_pkg, rse_front, rse_fifo, rse_back.
//
// Usage:
//  s_* channel takes one RGB pixel per transfer in raster order.
//  m_* channel gives results carrying row, column and enhanced value;
//  m_last_of_step marks the final result of each input pixel that yields any.
//  cfg_we/cfg_index/cfg_data write image_width (0) and image_height (1);
//  any write restarts the frame at row 0, column 0. Write only when idle.
// Flow:
//  The front takes one pixel at a time (registered line store read, then
//  write-back) into a four-entry queue. The back handles one pixel at a time:
//  it fetches it, runs a bitwise square root over the eight result bits for
//  an interior pixel, then gives each result as soon as the output is free.
//  Neither end takes a new pixel before it has handed on the last one; a pixel
//  with no result is dropped when fetched. m_valid is registered.
// Reset (aresetn, synchronous, low) clears position, window and queue and
//  restores 640x480. The line stores hold no reset value.
// A stalled m_ready holds the result; the queue fills, then s_ready stays low.
module rgb_sobel_edge_enhance #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [11:0] cfg_data,
    input  logic s_valid,
    output logic s_ready,
    input  logic [7:0] s_red,
    input  logic [7:0] s_green,
    input  logic [7:0] s_blue,
    output logic m_valid,
    input  logic m_ready,
    output logic [10:0] m_out_row,
    output logic [10:0] m_out_col,
    output logic [7:0] m_enhanced_pixel,
    output logic m_last_of_step
);
    logic f_valid, f_ready, b_valid, b_ready;
    rse_pkg::job_t f_job, b_job;

    rse_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .aclk, .aresetn, .cfg_we, .cfg_idx(cfg_index), .cfg_known(1'b1), .cfg_data,
        .s_valid, .s_ready, .s_red, .s_green, .s_blue,
        .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
    );

    rse_fifo u_fifo (
        .aclk, .aresetn, .in_valid(f_valid), .in_ready(f_ready), .in_job(f_job),
        .out_valid(b_valid), .out_ready(b_ready), .out_job(b_job)
    );

    rse_back u_back (
        .aclk, .aresetn, .job_valid(b_valid), .job_ready(b_ready), .job(b_job),
        .m_valid, .m_ready, .m_out_row, .m_out_col, .m_enhanced_pixel, .m_last_of_step
    );
endmodule

// File: tb/testbench.sv
// Self-checking bench for the RGB Sobel edge enhancer.
// Depends on rse_pkg and rgb_sobel_edge_enhance; predicts results in-bench.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXW = 2048;
    localparam int MAXH = 2048;
    localparam int CW = rse_pkg::COORD_W;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [CW-1:0] row;
        logic [CW-1:0] col;
        logic [7:0] value;
        logic last;
    } enh_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [0:0] cfg_index = rse_pkg::REG_WIDTH;
    logic [11:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [7:0] s_red = '0, s_green = '0, s_blue = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [10:0] m_out_row, m_out_col;
    logic [7:0] m_enhanced_pixel;
    logic m_last_of_step;

    rgb_sobel_edge_enhance dut (.*);

    // predictor state
    int unsigned img_w, img_h, pos_col, pos_row;
    logic [7:0] gray_up1 [MAXW];
    logic [7:0] gray_up2 [MAXW];
    logic [7:0] win [9];

    pixel_t pending_px[$];
    enh_t expected_enh[$];
    int errors = 0;
    longint cycles = 0;
    bit gaps_on = 1'b1;
    bit hold_on = 1'b0;        // long receiver hold
    bit run_drv = 1'b0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic int unsigned clip_size(int unsigned v, int unsigned mx);
        if (v == 0) return 1;
        if (v > mx) return mx;
        return v;
    endfunction

    function automatic logic [7:0] isqrt_clamped(int unsigned s);
        int unsigned r;
        r = 0;
        for (int b = 7; b >= 0; b--) begin
            if (((r | (1 << b)) * (r | (1 << b))) <= s) r = r | (1 << b);
        end
        return r[7:0];
    endfunction

    // work out the results of one accepted pixel
    task automatic predict_enhance(pixel_t px);
        int unsigned w, h, g, mg, sum, c, r;
        int sx, sy;
        logic [7:0] gy;
        int n0;
        w = clip_size(img_w, MAXW);
        h = clip_size(img_h, MAXH);
        g = (px.red + px.green + px.blue) / 3;
        gy = g[7:0];
        c = pos_col;
        r = pos_row;
        n0 = expected_enh.size();
        for (int i = 0; i < 3; i++) begin
            win[i*3] = win[i*3+1];
            win[i*3+1] = win[i*3+2];
        end
        win[2] = gray_up2[c % MAXW];
        win[5] = gray_up1[c % MAXW];
        win[8] = gy;
        gray_up2[c % MAXW] = gray_up1[c % MAXW];
        gray_up1[c % MAXW] = gy;
        if (r >= 2 && c >= 2 && r < h && c < w) begin
            sx = -win[0] + win[2] - 2*win[3] + 2*win[5] - win[6] + win[8];
            sy = -win[0] - 2*win[1] - win[2] + win[6] + 2*win[7] + win[8];
            mg = isqrt_clamped(sx*sx + sy*sy);
            sum = win[4] + mg;
            if (sum > 255) sum = 255;
            expected_enh.push_back('{row: CW'(r-1), col: CW'(c-1),
                                     value: sum[7:0], last: 1'b0});
        end
        if (r == 0 || c == 0 || r + 1 >= h || c + 1 >= w)
            expected_enh.push_back('{row: CW'(r), col: CW'(c),
                                     value: gy, last: 1'b0});
        if (expected_enh.size() > n0) expected_enh[$].last = 1'b1;
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        pos_col = c;
        pos_row = r;
    endtask

    // driver: presents queued pixels, with random gaps
    int drv_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_enhance('{red: s_red, green: s_green, blue: s_blue});
                void'(pending_px.pop_front());
            end
            if (drv_gap > 0) begin
                drv_gap <= drv_gap - 1;
                if (s_valid && s_ready) s_valid <= 1'b0;
            end else if (run_drv && pending_px.size() > 0) begin
                if (s_valid && !s_ready) begin
                    // hold the offered pixel
                end else if (gaps_on && $urandom_range(0, 9) == 0) begin
                    s_valid <= 1'b0;
                    drv_gap <= $urandom_range(1, 17) - 1;
                end else begin
                    pixel_t p;
                    p = pending_px[0];
                    s_valid <= 1'b1;
                    s_red <= p.red;
                    s_green <= p.green;
                    s_blue <= p.blue;
                end
            end else if (s_valid && s_ready) begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor: checks each result transfer and drives back-pressure
    int mon_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_enh.size() == 0) begin
                    $display("%0t unexpected result row %0d col %0d val %0d", $time,
                             m_out_row, m_out_col, m_enhanced_pixel);
                    errors++;
                end else begin
                    enh_t e;
                    e = expected_enh.pop_front();
                    if (e.row !== m_out_row) begin
                        $display("%0t row: expected %0d actual %0d", $time, e.row, m_out_row);
                        errors++;
                    end
                    if (e.col !== m_out_col) begin
                        $display("%0t col: expected %0d actual %0d", $time, e.col, m_out_col);
                        errors++;
                    end
                    if (e.value !== m_enhanced_pixel) begin
                        $display("%0t pixel: expected %0d actual %0d", $time, e.value,
                                 m_enhanced_pixel);
                        errors++;
                    end
                    if (e.last !== m_last_of_step) begin
                        $display("%0t last: expected %0d actual %0d", $time, e.last,
                                 m_last_of_step);
                        errors++;
                    end
                end
            end
            if (hold_on) begin
                m_ready <= 1'b0;
            end else if (mon_gap > 0) begin
                mon_gap <= mon_gap - 1;
                m_ready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 9) == 0) begin
                mon_gap <= $urandom_range(1, 17) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic wait_drained();
        while (pending_px.size() > 0 || s_valid || expected_enh.size() > 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(logic [0:0] idx, int unsigned val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[11:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == rse_pkg::REG_WIDTH) img_w = val[11:0];
        else img_h = val[11:0];
        pos_col = 0;
        pos_row = 0;
    endtask

    task automatic queue_pixels(int n, int mode);
        pixel_t p;
        for (int i = 0; i < n; i++) begin
            case (mode)
                0: p = {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255))};
                1: p = ($urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000);
                default: p = {3{8'($urandom_range(0, 1) * 255)}} ^ 24'($urandom);
            endcase
            pending_px.push_back(p);
        end
    endtask

    // sizes as {width, height}; mostly small frames so interiors and frame wrap are reached
    int sizes [][2] = '{'{3, 3}, '{1, 1}, '{0, 0}, '{2, 5}, '{5, 2}, '{4095, 1},
                         '{1, 4095}, '{7, 6}, '{16, 9}, '{4, 4}, '{2048, 3}, '{11, 13}};

    initial begin
        img_w = 640;
        img_h = 480;
        pos_col = 0;
        pos_row = 0;
        for (int i = 0; i < 9; i++) win[i] = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: 3x3 frames with extreme values, exercising both kernels
        write_reg(rse_pkg::REG_WIDTH, 3);
        write_reg(rse_pkg::REG_HEIGHT, 3);
        pending_px.push_back(24'hFFFFFF); pending_px.push_back(24'h000000);
        pending_px.push_back(24'hFFFFFF); pending_px.push_back(24'h010101);
        pending_px.push_back(24'hFFFE00); pending_px.push_back(24'h00FF00);
        pending_px.push_back(24'h0000FF); pending_px.push_back(24'hFF0000);
        pending_px.push_back(24'h000000);
        queue_pixels(9, 1);
        run_drv = 1'b1;
        wait_drained();

        // random frames over several sizes
        foreach (sizes[k]) begin
            write_reg(rse_pkg::REG_WIDTH, sizes[k][0]);
            write_reg(rse_pkg::REG_HEIGHT, sizes[k][1]);
            if (k == 5) begin
                // long receiver stall with the sender still offering
                fork
                    begin
                        hold_on <= 1'b1;
                        repeat (300) @(posedge aclk);
                        hold_on <= 1'b0;
                    end
                join_none
                queue_pixels(60, 0);
            end else begin
                queue_pixels(130, k % 3);
            end
            wait_drained();
        end

        // last part: no idling, full-rate stream
        gaps_on = 1'b0;
        write_reg(rse_pkg::REG_WIDTH, 8);
        write_reg(rse_pkg::REG_HEIGHT, 8);
        queue_pixels(290, 0);
        wait_drained();

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// File: filelist.f
rtl/rse_pkg.sv
rtl/rse_front.sv
rtl/rse_fifo.sv
rtl/rse_back.sv
rtl/rgb_sobel_edge_enhance.sv
tb/testbench.sv
